/* src/ipds_pkg.sv */
// Package for the image pair difference statistics core.
// Holds widths, register and statistic codes, the queued voxel type and the back-end states.
// No dependencies.
`timescale 1ns / 1ps
package ipds_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 32;
    localparam int REL_FRAC_BITS = 16;

    localparam int DIFF_BITS     = SAMPLE_BITS + 1;
    localparam int MAG_BITS      = SAMPLE_BITS;
    localparam int DSQ_BITS      = 2 * DIFF_BITS;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int REL_BITS      = DIFF_BITS + MAG_BITS;
    localparam int DIVIDEND_BITS = DIFF_BITS + REL_FRAC_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
    localparam int STAT_BITS     = 64;
    localparam int NUM_CLASS     = 13;
    localparam int NUM_STATS     = 18;
    localparam int IDX_BITS      = 5;
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;

    localparam logic [STAT_BITS-1:0] SAT_MAX = {1'b0, {(STAT_BITS-1){1'b1}}};

    // Configuration register indexes.
    localparam logic [2:0] REG_OIB       = 3'd0;
    localparam logic [2:0] REG_MASK_USED = 3'd1;
    localparam logic [2:0] REG_REF_PEN   = 3'd2;
    localparam logic [2:0] REG_REF_PVAL  = 3'd3;
    localparam logic [2:0] REG_TEST_PEN  = 3'd4;
    localparam logic [2:0] REG_TEST_PVAL = 3'd5;

    // Class counter slots.
    localparam int C_COUNT = 0;
    localparam int C_UNEQ  = 1;
    localparam int C_REC   = 2;
    localparam int C_SUB   = 3;
    localparam int C_REJ   = 4;
    localparam int C_RECF  = 5;
    localparam int C_SUBF  = 6;
    localparam int C_REJF  = 7;
    localparam int C_CNTF  = 8;
    localparam int C_RECM  = 9;
    localparam int C_SUBM  = 10;
    localparam int C_REJM  = 11;
    localparam int C_CNTM  = 12;

    // Statistic indexes.
    localparam logic [IDX_BITS-1:0] S_COUNT   = 5'd0;
    localparam logic [IDX_BITS-1:0] S_UNEQ    = 5'd1;
    localparam logic [IDX_BITS-1:0] S_SUMABS  = 5'd2;
    localparam logic [IDX_BITS-1:0] S_SUMSQ   = 5'd3;
    localparam logic [IDX_BITS-1:0] S_SUMMULT = 5'd4;
    localparam logic [IDX_BITS-1:0] S_MAXDIFF = 5'd5;
    localparam logic [IDX_BITS-1:0] S_MAXREL  = 5'd6;
    localparam logic [IDX_BITS-1:0] S_CLASS0  = 5'd7;
    localparam logic [IDX_BITS-1:0] S_LAST    = 5'd17;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] a;
        logic signed [SAMPLE_BITS-1:0] b;
        logic                          va;
        logic                          vb;
        logic                          in_region;
        logic                          fg;
        logic                          last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

/* src/ipds_front.sv */
// Front end: configuration registers and classification of each voxel request.
// Depends on ipds_pkg.
`timescale 1ns / 1ps
module ipds_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ipds_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [ipds_pkg::DATA_BITS-1:0]        pwdata,
    output logic [ipds_pkg::DATA_BITS-1:0]        prdata,
    input  logic signed [ipds_pkg::SAMPLE_BITS-1:0] sample_ref,
    input  logic                                  ref_valid,
    input  logic signed [ipds_pkg::SAMPLE_BITS-1:0] sample_test,
    input  logic                                  test_valid,
    input  logic                                  in_mask,
    input  logic                                  last_voxel,
    output ipds_pkg::item_t                       item
);

    logic                              oib_reg;
    logic                              mask_used_reg;
    logic                              ref_pen_reg;
    logic [ipds_pkg::SAMPLE_BITS-1:0]  ref_pval_reg;
    logic                              test_pen_reg;
    logic [ipds_pkg::SAMPLE_BITS-1:0]  test_pval_reg;
    logic                              wr_en;
    logic [2:0]                        reg_idx;
    logic                              vb_raw;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oib_reg       <= 1'b0;
            mask_used_reg <= 1'b0;
            ref_pen_reg   <= 1'b0;
            ref_pval_reg  <= '0;
            test_pen_reg  <= 1'b0;
            test_pval_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ipds_pkg::REG_OIB:       oib_reg       <= pwdata[0];
                ipds_pkg::REG_MASK_USED: mask_used_reg <= pwdata[0];
                ipds_pkg::REG_REF_PEN:   ref_pen_reg   <= pwdata[0];
                ipds_pkg::REG_REF_PVAL:  ref_pval_reg  <= pwdata[ipds_pkg::SAMPLE_BITS-1:0];
                ipds_pkg::REG_TEST_PEN:  test_pen_reg  <= pwdata[0];
                ipds_pkg::REG_TEST_PVAL: test_pval_reg <= pwdata[ipds_pkg::SAMPLE_BITS-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ipds_pkg::REG_OIB:       prdata = ipds_pkg::DATA_BITS'(oib_reg);
            ipds_pkg::REG_MASK_USED: prdata = ipds_pkg::DATA_BITS'(mask_used_reg);
            ipds_pkg::REG_REF_PEN:   prdata = ipds_pkg::DATA_BITS'(ref_pen_reg);
            ipds_pkg::REG_REF_PVAL:  prdata = ipds_pkg::DATA_BITS'(ref_pval_reg);
            ipds_pkg::REG_TEST_PEN:  prdata = ipds_pkg::DATA_BITS'(test_pen_reg);
            ipds_pkg::REG_TEST_PVAL: prdata = ipds_pkg::DATA_BITS'(test_pval_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        item.a         = sample_ref;
        item.va        = ref_valid && !(ref_pen_reg && (sample_ref == ref_pval_reg));
        vb_raw         = test_valid && !(test_pen_reg && (sample_test == test_pval_reg));
        item.b         = (!vb_raw && oib_reg) ? '0 : sample_test;
        item.vb        = vb_raw || oib_reg;
        item.fg        = (sample_ref != '0);
        item.in_region = !mask_used_reg || in_mask;
        item.last      = last_voxel;
    end

endmodule

/* src/ipds_queue.sv */
// Two-entry queue of classified voxels between the front and back ends.
// Depends on ipds_pkg.
`timescale 1ns / 1ps
module ipds_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ipds_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output ipds_pkg::item_t pop_item
);

    ipds_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* src/ipds_back.sv */
// Back end: accumulates statistics, divides out the relative maximum and sends 18 results.
// Depends on ipds_pkg.
`timescale 1ns / 1ps
module ipds_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_not_empty,
    input  ipds_pkg::item_t                     q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ipds_pkg::IDX_BITS-1:0]       stat_index,
    output logic signed [ipds_pkg::STAT_BITS-1:0] stat_value,
    output logic                                last_stat
);

    localparam int SB = ipds_pkg::STAT_BITS;

    ipds_pkg::back_state_t state_reg, state_next;

    ipds_pkg::item_t                     item_reg;
    logic [ipds_pkg::DIFF_BITS-1:0]      d_reg;
    logic [ipds_pkg::MAG_BITS-1:0]       m_reg;
    logic [ipds_pkg::DSQ_BITS-1:0]       dsq_reg;
    logic signed [ipds_pkg::PROD_BITS-1:0] prod_reg;
    logic [ipds_pkg::REL_BITS-1:0]       lhs_reg;
    logic [ipds_pkg::REL_BITS-1:0]       rhs_reg;

    logic [SB-1:0]                       sum_abs_reg;
    logic [SB-1:0]                       sum_sq_reg;
    logic [SB-1:0]                       sum_prod_reg;
    logic [ipds_pkg::DIFF_BITS-1:0]      max_diff_reg;
    logic [ipds_pkg::DIFF_BITS-1:0]      rel_num_reg;
    logic [ipds_pkg::MAG_BITS-1:0]       rel_den_reg;
    logic [ipds_pkg::COUNT_BITS-1:0]     class_reg [ipds_pkg::NUM_CLASS];

    logic [ipds_pkg::MAG_BITS-1:0]       div_rem_reg;
    logic [ipds_pkg::DIVIDEND_BITS-1:0]  div_q_reg;
    logic [ipds_pkg::DIV_CNT_BITS-1:0]   div_cnt_reg;
    logic [ipds_pkg::IDX_BITS-1:0]       emit_idx_reg;

    logic                                out_valid_reg;
    logic [ipds_pkg::IDX_BITS-1:0]       out_idx_reg;
    logic [SB-1:0]                       out_value_reg;
    logic                                out_last_reg;

    logic signed [ipds_pkg::DIFF_BITS-1:0] diff;
    logic [ipds_pkg::DIFF_BITS-1:0]      d_abs;
    logic [ipds_pkg::MAG_BITS-1:0]       mag_a;
    logic [ipds_pkg::MAG_BITS-1:0]       mag_b;
    logic [ipds_pkg::MAG_BITS-1:0]       mag_max;

    logic                                both;
    logic                                take;
    logic                                rel_upd;
    logic [ipds_pkg::DIFF_BITS-1:0]      rel_num_new;
    logic [SB-1:0]                       abs_sum;
    logic [SB-1:0]                       sq_sum;
    logic [ipds_pkg::NUM_CLASS-1:0]      bump;
    logic [ipds_pkg::MAG_BITS:0]         div_cat;
    logic                                div_ge;
    logic                                out_load;
    logic [SB-1:0]                       stat_mux;

    assign diff  = ipds_pkg::DIFF_BITS'(q_item.a) - ipds_pkg::DIFF_BITS'(q_item.b);
    assign d_abs = diff[ipds_pkg::DIFF_BITS-1] ? ipds_pkg::DIFF_BITS'(-diff)
                                               : ipds_pkg::DIFF_BITS'(diff);
    assign mag_a = q_item.a[ipds_pkg::SAMPLE_BITS-1] ? ipds_pkg::MAG_BITS'(-q_item.a)
                                                     : ipds_pkg::MAG_BITS'(q_item.a);
    assign mag_b = q_item.b[ipds_pkg::SAMPLE_BITS-1] ? ipds_pkg::MAG_BITS'(-q_item.b)
                                                     : ipds_pkg::MAG_BITS'(q_item.b);
    assign mag_max = (mag_a > mag_b) ? mag_a : mag_b;

    assign both    = item_reg.va && item_reg.vb;
    assign take    = both && item_reg.in_region;
    assign rel_upd = take && (m_reg != '0) && (lhs_reg > rhs_reg);
    assign rel_num_new = rel_upd ? d_reg : rel_num_reg;
    assign abs_sum = sum_abs_reg + SB'(d_reg);
    assign sq_sum  = sum_sq_reg + SB'(dsq_reg);

    always_comb
    begin
        bump = '0;
        if (both)
        begin
            bump[ipds_pkg::C_COUNT] = 1'b1;
            bump[ipds_pkg::C_CNTF]  = item_reg.fg;
            bump[ipds_pkg::C_CNTM]  = item_reg.in_region;
            if (item_reg.a == item_reg.b)
            begin
                bump[ipds_pkg::C_REC]  = 1'b1;
                bump[ipds_pkg::C_RECF] = item_reg.fg;
                bump[ipds_pkg::C_RECM] = item_reg.in_region;
            end
            else
            begin
                bump[ipds_pkg::C_SUB]  = 1'b1;
                bump[ipds_pkg::C_SUBF] = item_reg.fg;
                bump[ipds_pkg::C_SUBM] = item_reg.in_region;
                bump[ipds_pkg::C_UNEQ] = 1'b1;
            end
        end
        else
        begin
            if (item_reg.va)
            begin
                bump[ipds_pkg::C_REJ]  = 1'b1;
                bump[ipds_pkg::C_CNTF] = item_reg.fg;
                bump[ipds_pkg::C_REJF] = item_reg.fg;
                bump[ipds_pkg::C_CNTM] = item_reg.in_region;
                bump[ipds_pkg::C_REJM] = item_reg.in_region;
            end
            bump[ipds_pkg::C_UNEQ] = item_reg.va || item_reg.vb;
        end
    end

    assign div_cat = {div_rem_reg, div_q_reg[ipds_pkg::DIVIDEND_BITS-1]};
    assign div_ge  = (div_cat >= {1'b0, rel_den_reg});

    always_comb
    begin
        case (emit_idx_reg)
            ipds_pkg::S_COUNT:   stat_mux = SB'(class_reg[ipds_pkg::C_COUNT]);
            ipds_pkg::S_UNEQ:    stat_mux = SB'(class_reg[ipds_pkg::C_UNEQ]);
            ipds_pkg::S_SUMABS:  stat_mux = sum_abs_reg;
            ipds_pkg::S_SUMSQ:   stat_mux = sum_sq_reg;
            ipds_pkg::S_SUMMULT: stat_mux = sum_prod_reg;
            ipds_pkg::S_MAXDIFF: stat_mux = SB'(max_diff_reg);
            ipds_pkg::S_MAXREL:  stat_mux = SB'(div_q_reg);
            default:
            begin
                if (emit_idx_reg >= ipds_pkg::S_CLASS0 && emit_idx_reg <= ipds_pkg::S_LAST)
                begin
                    stat_mux = SB'(class_reg[4'(emit_idx_reg - ipds_pkg::S_CLASS0)
                                             + 4'(ipds_pkg::C_REC)]);
                end
                else
                begin
                    stat_mux = '0;
                end
            end
        endcase
    end

    assign out_load = (state_reg == ipds_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ipds_pkg::ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ipds_pkg::ST_MUL;
                end
            end
            ipds_pkg::ST_MUL:
            begin
                state_next = ipds_pkg::ST_ACC;
            end
            ipds_pkg::ST_ACC:
            begin
                state_next = item_reg.last ? ipds_pkg::ST_DIV : ipds_pkg::ST_IDLE;
            end
            ipds_pkg::ST_DIV:
            begin
                if (div_cnt_reg == ipds_pkg::DIV_CNT_BITS'(ipds_pkg::DIVIDEND_BITS - 1))
                begin
                    state_next = ipds_pkg::ST_EMIT;
                end
            end
            ipds_pkg::ST_EMIT:
            begin
                if (out_load && emit_idx_reg == ipds_pkg::S_LAST)
                begin
                    state_next = ipds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ipds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipds_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
            d_reg    <= d_abs;
            m_reg    <= mag_max;
        end
        if (state_reg == ipds_pkg::ST_MUL)
        begin
            dsq_reg  <= d_reg * d_reg;
            prod_reg <= item_reg.a * item_reg.b;
            lhs_reg  <= d_reg * rel_den_reg;
            rhs_reg  <= rel_num_reg * m_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_abs_reg  <= '0;
            sum_sq_reg   <= '0;
            sum_prod_reg <= '0;
            max_diff_reg <= '0;
            rel_num_reg  <= '0;
            rel_den_reg  <= ipds_pkg::MAG_BITS'(1);
            for (int i = 0; i < ipds_pkg::NUM_CLASS; i++)
            begin
                class_reg[i] <= '0;
            end
            div_rem_reg  <= '0;
            div_q_reg    <= '0;
            div_cnt_reg  <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            if (state_reg == ipds_pkg::ST_ACC)
            begin
                if (take)
                begin
                    sum_abs_reg  <= abs_sum[SB-1] ? ipds_pkg::SAT_MAX : abs_sum;
                    sum_sq_reg   <= sq_sum[SB-1] ? ipds_pkg::SAT_MAX : sq_sum;
                    sum_prod_reg <= sum_prod_reg + SB'(prod_reg);
                    if (d_reg > max_diff_reg)
                    begin
                        max_diff_reg <= d_reg;
                    end
                end
                if (rel_upd)
                begin
                    rel_num_reg <= d_reg;
                    rel_den_reg <= m_reg;
                end
                for (int i = 0; i < ipds_pkg::NUM_CLASS; i++)
                begin
                    if (bump[i])
                    begin
                        class_reg[i] <= class_reg[i] + 1'b1;
                    end
                end
                div_rem_reg  <= '0;
                div_q_reg    <= {rel_num_new, {ipds_pkg::REL_FRAC_BITS{1'b0}}};
                div_cnt_reg  <= '0;
                emit_idx_reg <= '0;
            end
            if (state_reg == ipds_pkg::ST_DIV)
            begin
                div_rem_reg <= div_ge ? ipds_pkg::MAG_BITS'(div_cat - {1'b0, rel_den_reg})
                                      : ipds_pkg::MAG_BITS'(div_cat);
                div_q_reg   <= {div_q_reg[ipds_pkg::DIVIDEND_BITS-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
                if (emit_idx_reg == ipds_pkg::S_LAST)
                begin
                    sum_abs_reg  <= '0;
                    sum_sq_reg   <= '0;
                    sum_prod_reg <= '0;
                    max_diff_reg <= '0;
                    rel_num_reg  <= '0;
                    rel_den_reg  <= ipds_pkg::MAG_BITS'(1);
                    for (int i = 0; i < ipds_pkg::NUM_CLASS; i++)
                    begin
                        class_reg[i] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg   <= emit_idx_reg;
            out_value_reg <= stat_mux;
            out_last_reg  <= (emit_idx_reg == ipds_pkg::S_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign stat_index = out_idx_reg;
    assign stat_value = out_value_reg;
    assign last_stat  = out_last_reg;

endmodule

/* src/image_pair_difference_statistics_core.sv */
// Top level of the image pair difference statistics core.
// Depends on ipds_pkg, ipds_front, ipds_queue and ipds_back.
`timescale 1ns / 1ps
// Voxel pairs enter on the input channel (in_valid/in_ready), one request per
// pair, with validity, mask and end-of-run bits. The front end classifies each
// request against the padding registers and pushes it into a two-entry queue.
// The back end takes each queued voxel in order: it latches the voxel, forms the
// difference products, then accumulates, and it pops no new voxel until it has
// accumulated the last one, so this accumulation sequence sets the sustained rate.
// A voxel marked last is followed by a restoring division for the maximum
// relative difference, then 18 statistics leave on the output channel
// (out_valid/out_ready), one per cycle while the receiver is ready, the final
// one flagged by last_stat. A stalled receiver holds the output register; the
// queue keeps accepting until it is full, then in_ready drops.
// Reset clears all statistics and configuration registers. Configuration is to be
// written over the APB port only while the core is idle; the core itself does not
// enforce this. pready is always high.
module image_pair_difference_statistics_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ipds_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [ipds_pkg::DATA_BITS-1:0]        pwdata,
    output logic [ipds_pkg::DATA_BITS-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ipds_pkg::SAMPLE_BITS-1:0] sample_ref,
    input  logic                                  ref_valid,
    input  logic signed [ipds_pkg::SAMPLE_BITS-1:0] sample_test,
    input  logic                                  test_valid,
    input  logic                                  in_mask,
    input  logic                                  last_voxel,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ipds_pkg::IDX_BITS-1:0]         stat_index,
    output logic signed [ipds_pkg::STAT_BITS-1:0] stat_value,
    output logic                                  last_stat
);

    ipds_pkg::item_t front_item;
    ipds_pkg::item_t q_item;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;

    assign pready   = 1'b1;
    assign in_ready = !q_full;

    ipds_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .sample_ref  (sample_ref),
        .ref_valid   (ref_valid),
        .sample_test (sample_test),
        .test_valid  (test_valid),
        .in_mask     (in_mask),
        .last_voxel  (last_voxel),
        .item        (front_item)
    );

    ipds_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_item)
    );

    ipds_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stat_index  (stat_index),
        .stat_value  (stat_value),
        .last_stat   (last_stat)
    );

endmodule

/* src/ipds_checker.sv */
// Port-level checker for the image pair difference statistics core, with its bind.
// Depends on ipds_pkg and image_pair_difference_statistics_core.
`timescale 1ns / 1ps
module ipds_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  pready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [ipds_pkg::IDX_BITS-1:0]         stat_index,
    input logic signed [ipds_pkg::STAT_BITS-1:0] stat_value,
    input logic                                  last_stat
);

    // A stalled result must hold its index and value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(stat_index) && $stable(stat_value))
        else $error("stalled result changed");

    // The last flag marks exactly the final statistic.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_stat == (stat_index == ipds_pkg::S_LAST)))
        else $error("last_stat does not match the final index");

    // The maximum difference never exceeds the widened sample range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stat_index == ipds_pkg::S_MAXDIFF
        |-> stat_value[ipds_pkg::STAT_BITS-1:ipds_pkg::DIFF_BITS] == '0)
        else $error("maximum difference out of range");

    // The relative maximum is at most two, so only its low bits may be set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stat_index == ipds_pkg::S_MAXREL
        |-> stat_value[ipds_pkg::STAT_BITS-1:ipds_pkg::REL_FRAC_BITS+2] == '0)
        else $error("relative difference out of range");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind image_pair_difference_statistics_core ipds_checker u_ipds_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat_index (stat_index),
    .stat_value (stat_value),
    .last_stat  (last_stat)
);

/* tb/sv/tb_image_pair_difference_statistics_core.sv */
// Testbench for the image pair difference statistics core.
// Drives voxel pair requests and APB register writes, predicts the 18 statistics of each run.
// Depends on ipds_pkg and image_pair_difference_statistics_core.
`timescale 1ns / 1ps
module tb_image_pair_difference_statistics_core;

    typedef struct packed {
        logic signed [ipds_pkg::SAMPLE_BITS-1:0] a;
        logic                                    va;
        logic signed [ipds_pkg::SAMPLE_BITS-1:0] b;
        logic                                    vb;
        logic                                    m;
        logic                                    last;
    } voxel_t;

    typedef struct packed {
        logic [ipds_pkg::IDX_BITS-1:0]  idx;
        logic [ipds_pkg::STAT_BITS-1:0] val;
        logic                           lst;
    } stat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ipds_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [ipds_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [ipds_pkg::DATA_BITS-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [ipds_pkg::SAMPLE_BITS-1:0] sample_ref = '0, sample_test = '0;
    logic ref_valid = 1'b0, test_valid = 1'b0, in_mask = 1'b0, last_voxel = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [ipds_pkg::IDX_BITS-1:0] stat_index;
    logic signed [ipds_pkg::STAT_BITS-1:0] stat_value;
    logic last_stat;

    image_pair_difference_statistics_core dut (.*);

    always #2 clk = ~clk;

    // Register copies and accumulated statistics of the predictor.
    logic cfg_oib, cfg_mask, cfg_rpen, cfg_tpen;
    logic [15:0] cfg_rpv, cfg_tpv;
    logic [63:0] acc_abs, acc_sq, acc_prod;
    logic [63:0] max_d, rel_num, rel_den;
    logic [ipds_pkg::COUNT_BITS-1:0] cls [ipds_pkg::NUM_CLASS];

    voxel_t pending_voxels[$];
    stat_t  expected_stats[$];
    int errors = 0;
    longint cycles = 0;
    int hold_off = 0;
    int burst = 0, gap = 0;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic void clear_accumulators();
        acc_abs = '0; acc_sq = '0; acc_prod = '0;
        max_d = '0; rel_num = '0; rel_den = 64'd1;
        for (int i = 0; i < ipds_pkg::NUM_CLASS; i++) cls[i] = '0;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return (s > {1'b0, ipds_pkg::SAT_MAX}) ? ipds_pkg::SAT_MAX : s[63:0];
    endfunction

    function automatic void bump(input int i);
        cls[i] = cls[i] + 1'b1;
    endfunction

    function automatic void predict_voxel(input voxel_t v);
        longint a, b, d, ma, mb, mm;
        logic va, vb, ins, fg;
        logic [63:0] vals [ipds_pkg::NUM_STATS];
        stat_t s;
        a = longint'(v.a); b = longint'(v.b); va = v.va; vb = v.vb;
        ins = !cfg_mask || v.m;
        if (cfg_rpen && v.a == $signed(cfg_rpv)) va = 1'b0;
        if (cfg_tpen && v.b == $signed(cfg_tpv)) vb = 1'b0;
        if (!vb && cfg_oib) begin
            b = 0; vb = 1'b1;
        end
        fg = (a != 0);
        if (va && vb) begin
            if (ins) begin
                d = (a > b) ? a - b : b - a;
                ma = a < 0 ? -a : a;
                mb = b < 0 ? -b : b;
                mm = ma > mb ? ma : mb;
                acc_abs = sat_sum(acc_abs, d);
                acc_sq = sat_sum(acc_sq, d * d);
                acc_prod = acc_prod + a * b;
                if (d > max_d) max_d = d;
                if (mm != 0 && d * rel_den > rel_num * mm) begin
                    rel_num = d; rel_den = mm;
                end
            end
            bump(ipds_pkg::C_COUNT);
            if (fg) bump(ipds_pkg::C_CNTF);
            if (ins) bump(ipds_pkg::C_CNTM);
            if (a == b) begin
                bump(ipds_pkg::C_REC);
                if (fg) bump(ipds_pkg::C_RECF);
                if (ins) bump(ipds_pkg::C_RECM);
            end else begin
                bump(ipds_pkg::C_SUB);
                if (fg) bump(ipds_pkg::C_SUBF);
                if (ins) bump(ipds_pkg::C_SUBM);
                bump(ipds_pkg::C_UNEQ);
            end
        end else begin
            if (va) begin
                bump(ipds_pkg::C_REJ);
                if (fg) begin
                    bump(ipds_pkg::C_CNTF); bump(ipds_pkg::C_REJF);
                end
                if (ins) begin
                    bump(ipds_pkg::C_CNTM); bump(ipds_pkg::C_REJM);
                end
            end
            if (va || vb) bump(ipds_pkg::C_UNEQ);
        end
        if (!v.last) return;
        vals[0] = 64'(cls[ipds_pkg::C_COUNT]);
        vals[1] = 64'(cls[ipds_pkg::C_UNEQ]);
        vals[2] = acc_abs;
        vals[3] = acc_sq;
        vals[4] = acc_prod;
        vals[5] = max_d;
        vals[6] = (rel_num << ipds_pkg::REL_FRAC_BITS) / rel_den;
        for (int k = 7; k < ipds_pkg::NUM_STATS; k++)
            vals[k] = 64'(cls[ipds_pkg::C_REC + k - 7]);
        for (int k = 0; k < ipds_pkg::NUM_STATS; k++) begin
            s.idx = k[ipds_pkg::IDX_BITS-1:0];
            s.val = vals[k];
            s.lst = (k == ipds_pkg::NUM_STATS - 1);
            expected_stats.push_back(s);
        end
        clear_accumulators();
    endfunction

    task automatic write_reg(input logic [2:0] r, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {r, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            ipds_pkg::REG_OIB:       cfg_oib = val[0];
            ipds_pkg::REG_MASK_USED: cfg_mask = val[0];
            ipds_pkg::REG_REF_PEN:   cfg_rpen = val[0];
            ipds_pkg::REG_REF_PVAL:  cfg_rpv = val[15:0];
            ipds_pkg::REG_TEST_PEN:  cfg_tpen = val[0];
            ipds_pkg::REG_TEST_PVAL: cfg_tpv = val[15:0];
            default:                 ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_sample(input logic signed [15:0] pad);
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return pad;
            4, 5: return $signed(16'($urandom_range(0, 20)) - 16'd10);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic voxel_t rand_voxel(input logic is_last);
        voxel_t v;
        v.a = pick_sample(cfg_rpv);
        v.b = ($urandom_range(0, 3) == 0) ? v.a : pick_sample(cfg_tpv);
        v.va = ($urandom_range(0, 4) != 0);
        v.vb = ($urandom_range(0, 4) != 0);
        v.m = 1'($urandom);
        v.last = is_last;
        return v;
    endfunction

    task automatic wait_idle();
        while (pending_voxels.size() != 0 || in_valid || expected_stats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic voxel_t mk(input logic signed [15:0] a, input logic va,
                                  input logic signed [15:0] b, input logic vb,
                                  input logic m, input logic l);
        voxel_t v;
        v.a = a; v.va = va; v.b = b; v.vb = vb; v.m = m; v.last = l;
        return v;
    endfunction

    // Voxel request driver: bursts with random gaps.
    always @(posedge clk) begin
        if (!in_valid || in_ready) begin
            if (pending_voxels.size() != 0 && gap == 0) begin
                voxel_t v;
                v = pending_voxels.pop_front();
                predict_voxel(v);
                in_valid <= 1'b1;
                sample_ref <= v.a; ref_valid <= v.va;
                sample_test <= v.b; test_valid <= v.vb;
                in_mask <= v.m; last_voxel <= v.last;
                if (burst == 0) begin
                    burst = $urandom_range(1, 12);
                    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                end else begin
                    burst--;
                end
            end else begin
                in_valid <= 1'b0;
                if (gap != 0) gap--;
            end
        end
    end

    // Statistic monitor.
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (expected_stats.size() == 0) begin
                report("statistic with none expected");
            end else begin
                stat_t e;
                e = expected_stats.pop_front();
                if (stat_index !== e.idx)
                    report($sformatf("index %0d, expected %0d", stat_index, e.idx));
                if (stat_value !== e.val)
                    report($sformatf("stat %0d value %h, expected %h", e.idx, stat_value, e.val));
                if (last_stat !== e.lst)
                    report($sformatf("stat %0d last flag %b", e.idx, last_stat));
            end
        end
    end

    // Receiver stall pattern with a long hold-off counted in cycles.
    always @(posedge clk) begin
        if (hold_off != 0) begin
            hold_off--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (cycles[9:7] == 3'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("FAIL image_pair_difference_statistics_core");
            $finish;
        end
    end

    initial begin
        int settings;
        clear_accumulators();
        cfg_oib = 1'b0; cfg_mask = 1'b0; cfg_rpen = 1'b0; cfg_tpen = 1'b0;
        cfg_rpv = '0; cfg_tpv = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed runs with default registers: extremes, equal and invalid pairs.
        pending_voxels.push_back(mk(16'sh7FFF, 1, 16'sh8000, 1, 1, 0));
        pending_voxels.push_back(mk(16'sh8000, 1, 16'sh7FFF, 1, 0, 0));
        pending_voxels.push_back(mk(16'sh8000, 1, 16'sh8000, 1, 1, 0));
        pending_voxels.push_back(mk(0, 1, 0, 1, 1, 0));
        pending_voxels.push_back(mk(5, 1, 3, 0, 1, 0));
        pending_voxels.push_back(mk(0, 0, 3, 1, 1, 0));
        pending_voxels.push_back(mk(7, 0, 7, 0, 1, 0));
        pending_voxels.push_back(mk(-3, 1, 6, 1, 0, 1));
        pending_voxels.push_back(mk(9, 1, 9, 1, 1, 1));
        wait_idle();

        // Directed run with every register set: padding, background and mask.
        write_reg(ipds_pkg::REG_OIB, 1);
        write_reg(ipds_pkg::REG_MASK_USED, 1);
        write_reg(ipds_pkg::REG_REF_PEN, 1);
        write_reg(ipds_pkg::REG_REF_PVAL, 32'h0000_8000);
        write_reg(ipds_pkg::REG_TEST_PEN, 1);
        write_reg(ipds_pkg::REG_TEST_PVAL, 32'h0000_7FFF);
        pending_voxels.push_back(mk(16'sh8000, 1, 4, 1, 1, 0));
        pending_voxels.push_back(mk(4, 1, 16'sh7FFF, 1, 1, 0));
        pending_voxels.push_back(mk(0, 1, 2, 0, 0, 0));
        pending_voxels.push_back(mk(-6, 1, 2, 1, 0, 0));
        pending_voxels.push_back(mk(-6, 1, 2, 1, 1, 0));
        pending_voxels.push_back(mk(16'sh7FFF, 1, 16'sh8000, 0, 1, 1));
        wait_idle();

        // Long receiver hold-off while requests keep coming.
        hold_off = 300;
        for (int i = 0; i < 12; i++) pending_voxels.push_back(rand_voxel(i % 5 == 4));
        wait_idle();

        // Random phases across register settings.
        settings = 0;
        while (settings < 8) begin
            int runs;
            write_reg(ipds_pkg::REG_OIB, $urandom_range(0, 1));
            write_reg(ipds_pkg::REG_MASK_USED, $urandom_range(0, 1));
            write_reg(ipds_pkg::REG_REF_PEN, $urandom_range(0, 1));
            write_reg(ipds_pkg::REG_REF_PVAL,
                      (settings == 1) ? 32'h7FFF : (settings == 2) ? 32'h0 : $urandom);
            write_reg(ipds_pkg::REG_TEST_PEN, $urandom_range(0, 1));
            write_reg(ipds_pkg::REG_TEST_PVAL, (settings == 1) ? 32'h8000 : $urandom);
            runs = 2;
            for (int r = 0; r < runs; r++) begin
                int len;
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) pending_voxels.push_back(rand_voxel(i == len - 1));
            end
            wait_idle();
            settings++;
        end
        if (errors == 0) begin
            $display("PASS image_pair_difference_statistics_core");
        end else begin
            $display("FAIL image_pair_difference_statistics_core");
        end
        $finish;
    end
endmodule

/* sim.f */
src/ipds_pkg.sv
src/ipds_front.sv
src/ipds_queue.sv
src/ipds_back.sv
src/image_pair_difference_statistics_core.sv
src/ipds_checker.sv
tb/sv/tb_image_pair_difference_statistics_core.sv
